### design/ertu_pkg.sv
// Shared types and constants for the external route table upsert block.
// No dependencies; used by ertu_ctrl, ertu_dp and the top level.
package ertu_pkg;

    localparam int DEST_W    = 32;
    localparam int PLEN_W    = 6;
    localparam int HOP_W     = 32;
    localparam int COST_W    = 24;
    localparam int RID_W     = 32;
    localparam int IDX_OUT_W = 6;
    localparam int STAT_W    = 2;

    typedef enum logic [STAT_W-1:0] {
        ST_UNCHANGED = 2'd0,
        ST_UPDATED   = 2'd1,
        ST_ADDED     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic start;   // latch the route and rewind the scan
        logic search;  // advance the scan
        logic commit;  // write back and load the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hit;     // registered read data matches the route
        logic done;    // every stored entry has been checked
    } t_dp_stat;

endpackage

### design/external_route_table_upsert.sv
// Top level of the external route table upsert block: controller plus datapath.
// Depends on ertu_pkg, ertu_ctrl and ertu_dp.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------------
//  route in | i_in_valid / o_in_ready    | i_destination i_prefix_len i_next_hop i_metric
//  result   | o_out_valid / i_out_ready  | o_status o_originate o_entry_index
//           |                            | o_lsa_link_state_id o_lsa_advertising_router
//  config   | i_cfg_we (no wait)         | i_cfg_wdata (router id)
//
// One route beat at a time: the scan stops at a matching slot, or on a miss once every
// stored entry is checked; it reads one entry per cycle from the single-read-port entry
// memory. The next route beat is taken while a result beat waits; its write-back holds
// until that result beat is taken.
// Synchronous active-low reset empties the table at once (entry count to zero).
module external_route_table_upsert #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ertu_pkg::RID_W-1:0]     i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [ertu_pkg::DEST_W-1:0]    i_destination,
    input  logic [ertu_pkg::PLEN_W-1:0]    i_prefix_len,
    input  logic [ertu_pkg::HOP_W-1:0]     i_next_hop,
    input  logic [ertu_pkg::COST_W-1:0]    i_metric,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [ertu_pkg::STAT_W-1:0]    o_status,
    output logic                           o_originate,
    output logic [ertu_pkg::IDX_OUT_W-1:0] o_entry_index,
    output logic [ertu_pkg::DEST_W-1:0]    o_lsa_link_state_id,
    output logic [ertu_pkg::RID_W-1:0]     o_lsa_advertising_router
);

    ertu_pkg::t_cmd     w_cmd;
    ertu_pkg::t_dp_stat w_stat;

    ertu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    ertu_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_cmd                    (w_cmd),
        .o_stat                   (w_stat),
        .i_cfg_we                 (i_cfg_we),
        .i_cfg_wdata              (i_cfg_wdata),
        .i_destination            (i_destination),
        .i_prefix_len             (i_prefix_len),
        .i_next_hop               (i_next_hop),
        .i_metric                 (i_metric),
        .o_status                 (o_status),
        .o_originate              (o_originate),
        .o_entry_index            (o_entry_index),
        .o_lsa_link_state_id      (o_lsa_link_state_id),
        .o_lsa_advertising_router (o_lsa_advertising_router)
    );

endmodule

### design/ertu_dp.sv
// Datapath: route registers, entry memory with linear scan, write-back and result register.
// Depends on ertu_pkg; driven by commands from ertu_ctrl.
module ertu_dp #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ertu_pkg::t_cmd                 i_cmd,
    output ertu_pkg::t_dp_stat             o_stat,
    input  logic                           i_cfg_we,
    input  logic [ertu_pkg::RID_W-1:0]     i_cfg_wdata,
    input  logic [ertu_pkg::DEST_W-1:0]    i_destination,
    input  logic [ertu_pkg::PLEN_W-1:0]    i_prefix_len,
    input  logic [ertu_pkg::HOP_W-1:0]     i_next_hop,
    input  logic [ertu_pkg::COST_W-1:0]    i_metric,
    output logic [ertu_pkg::STAT_W-1:0]    o_status,
    output logic                           o_originate,
    output logic [ertu_pkg::IDX_OUT_W-1:0] o_entry_index,
    output logic [ertu_pkg::DEST_W-1:0]    o_lsa_link_state_id,
    output logic [ertu_pkg::RID_W-1:0]     o_lsa_advertising_router
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W = ertu_pkg::DEST_W + ertu_pkg::PLEN_W;
    localparam int IDX_OUT_W_L = ertu_pkg::IDX_OUT_W;

    logic [ertu_pkg::RID_W-1:0]  r_router_id;
    logic [ertu_pkg::DEST_W-1:0] r_dest;
    logic [ertu_pkg::PLEN_W-1:0] r_plen;
    logic [ertu_pkg::HOP_W-1:0]  r_hop;
    logic [ertu_pkg::COST_W-1:0] r_metric;

    logic [KEY_W-1:0]            r_mem_key  [TABLE_DEPTH];
    logic [ertu_pkg::HOP_W-1:0]  r_mem_hop  [TABLE_DEPTH];
    logic [ertu_pkg::COST_W-1:0] r_mem_cost [TABLE_DEPTH];

    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            r_issue;
    logic                        r_data_vld;
    logic [IDX_W-1:0]            r_data_idx;
    logic [KEY_W-1:0]            r_rd_key;
    logic [ertu_pkg::COST_W-1:0] r_rd_cost;

    ertu_pkg::t_status           r_status;
    logic                        r_orig;
    logic [IDX_OUT_W_L-1:0]      r_idx;
    logic [ertu_pkg::DEST_W-1:0] r_lsa_id;
    logic [ertu_pkg::RID_W-1:0]  r_lsa_adv;

    logic             w_hit;
    logic             w_done;
    logic             w_issue;
    logic             w_full;
    logic             w_diff;
    logic             w_cost_we;
    logic             w_add_we;
    logic [IDX_W-1:0] w_rd_addr;
    logic [IDX_W-1:0] w_wr_addr;
    logic [31:0]      w_idx_ext;

    assign w_hit     = r_data_vld && (r_rd_key == {r_dest, r_plen});
    assign w_done    = !r_data_vld && (r_issue == r_count);
    assign w_issue   = i_cmd.search && !w_hit && (r_issue != r_count);
    assign w_rd_addr = r_issue[IDX_W-1:0];
    assign w_full    = (r_count == CNT_W'(TABLE_DEPTH));
    assign w_diff    = (r_rd_cost != r_metric);
    assign w_wr_addr = w_hit ? r_data_idx : r_count[IDX_W-1:0];
    assign w_idx_ext = 32'(w_wr_addr);
    assign w_add_we  = i_cmd.commit && !w_hit && !w_full;
    assign w_cost_we = i_cmd.commit && ((w_hit && w_diff) || (!w_hit && !w_full));

    assign o_stat.hit  = w_hit;
    assign o_stat.done = w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_router_id <= '0;
        end else if (i_cfg_we) begin
            r_router_id <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_dest   <= i_destination;
            r_plen   <= i_prefix_len;
            r_hop    <= i_next_hop;
            r_metric <= i_metric;
        end
    end

    // scan pointer: stop on a hit so the matching beat stays in the read register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue    <= '0;
            r_data_vld <= 1'b0;
            r_count    <= '0;
        end else begin
            if (i_cmd.start) begin
                r_issue    <= '0;
                r_data_vld <= 1'b0;
            end else if (i_cmd.search && !w_hit) begin
                r_data_vld <= w_issue;
                if (w_issue) begin
                    r_issue <= r_issue + 1'b1;
                end
            end
            if (w_add_we) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_key   <= r_mem_key[w_rd_addr];
            r_data_idx <= w_rd_addr;
        end
        if (w_add_we) begin
            r_mem_key[w_wr_addr] <= {r_dest, r_plen};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_cost <= r_mem_cost[w_rd_addr];
        end
        if (w_cost_we) begin
            r_mem_cost[w_wr_addr] <= r_metric;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_add_we) begin
            r_mem_hop[w_wr_addr] <= r_hop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (w_hit) begin
                r_status  <= w_diff ? ertu_pkg::ST_UPDATED : ertu_pkg::ST_UNCHANGED;
                r_orig    <= w_diff;
                r_idx     <= w_idx_ext[IDX_OUT_W_L-1:0];
                r_lsa_id  <= w_diff ? r_dest : '0;
                r_lsa_adv <= w_diff ? r_router_id : '0;
            end else if (!w_full) begin
                r_status  <= ertu_pkg::ST_ADDED;
                r_orig    <= 1'b1;
                r_idx     <= w_idx_ext[IDX_OUT_W_L-1:0];
                r_lsa_id  <= r_dest;
                r_lsa_adv <= r_router_id;
            end else begin
                r_status  <= ertu_pkg::ST_FULL;
                r_orig    <= 1'b0;
                r_idx     <= '0;
                r_lsa_id  <= '0;
                r_lsa_adv <= '0;
            end
        end
    end

    assign o_status                 = r_status;
    assign o_originate              = r_orig;
    assign o_entry_index            = r_idx;
    assign o_lsa_link_state_id      = r_lsa_id;
    assign o_lsa_advertising_router = r_lsa_adv;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_add_we |=> r_count == $past(r_count) + 1'b1)
        else $error("append did not advance entry count");

    a_hit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.search && w_hit) |=> w_hit)
        else $error("matching entry lost before write-back");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue <= r_count)
        else $error("scan pointer past valid entries");

endmodule

### design/ertu_ctrl.sv
// Controller: sequences accept, scan and write-back, and owns the result valid flag.
// Depends on ertu_pkg; drives ertu_dp through command and status structs.
module ertu_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ertu_pkg::t_cmd     o_cmd,
    input  ertu_pkg::t_dp_stat i_stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;
    logic   w_accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign w_accept    = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.start  = w_accept;
        o_cmd.search = (r_state == S_SEARCH);
        // hold write-back while the previous result beat is still waiting
        o_cmd.commit = (r_state == S_COMMIT) && (!r_out_vld || i_out_ready);
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_stat.hit || i_stat.done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (o_cmd.commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_vld = o_cmd.commit || (r_out_vld && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    a_accept_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_SEARCH)
        else $error("accepted beat did not start a scan");

    a_commit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_out_vld && r_state == S_IDLE)
        else $error("write-back did not present a result");

    a_scan_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH && i_stat.hit) |=> r_state == S_COMMIT)
        else $error("scan ran on past a match");

endmodule

### test/tb_external_route_table_upsert.sv
// Testbench for external_route_table_upsert: directed route beats, then random phases.
// A local table model predicts each result; depends on ertu_pkg and the RTL only.
module tb_external_route_table_upsert;

    localparam int DEPTH     = 64;
    localparam int DRAIN     = DEPTH + 8;
    localparam int LIMIT     = 400000;
    localparam int HOLD_LEN  = 400;
    localparam int PHASE_LEN = 160;
    localparam int N_DIR     = 16;

    typedef struct packed {
        logic [ertu_pkg::DEST_W-1:0]    lsid;
        logic [ertu_pkg::RID_W-1:0]     adv;
        ertu_pkg::t_status              status;
        logic                           originate;
        logic [ertu_pkg::IDX_OUT_W-1:0] idx;
    } t_upsert_result;

    typedef struct packed {
        logic [ertu_pkg::DEST_W-1:0]    dest;
        logic [ertu_pkg::PLEN_W-1:0]    plen;
        logic [ertu_pkg::HOP_W-1:0]     hop;
        logic [ertu_pkg::COST_W-1:0]    metric;
        logic                           typed;
        ertu_pkg::t_status              status;
        logic                           orig;
        logic [ertu_pkg::IDX_OUT_W-1:0] idx;
    } t_route_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [ertu_pkg::RID_W-1:0]     i_cfg_wdata = '0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    logic [ertu_pkg::DEST_W-1:0]    i_destination = '0;
    logic [ertu_pkg::PLEN_W-1:0]    i_prefix_len = '0;
    logic [ertu_pkg::HOP_W-1:0]     i_next_hop = '0;
    logic [ertu_pkg::COST_W-1:0]    i_metric = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic [ertu_pkg::STAT_W-1:0]    o_status;
    logic                           o_originate;
    logic [ertu_pkg::IDX_OUT_W-1:0] o_entry_index;
    logic [ertu_pkg::DEST_W-1:0]    o_lsa_link_state_id;
    logic [ertu_pkg::RID_W-1:0]     o_lsa_advertising_router;

    // typed expectation riding along with the current route beat
    logic                           row_typed = 1'b0;
    ertu_pkg::t_status              row_status = ertu_pkg::ST_UNCHANGED;
    logic                           row_orig = 1'b0;
    logic [ertu_pkg::IDX_OUT_W-1:0] row_idx = '0;

    logic steady = 1'b0;
    logic hold_go = 1'b0;
    logic out_hold = 1'b0;

    // local copy of the route table
    logic [ertu_pkg::DEST_W-1:0] tbl_dest [DEPTH];
    logic [ertu_pkg::PLEN_W-1:0] tbl_plen [DEPTH];
    logic [ertu_pkg::HOP_W-1:0]  tbl_hop  [DEPTH];
    logic [ertu_pkg::COST_W-1:0] tbl_cost [DEPTH];
    int                          tbl_count = 0;
    logic [ertu_pkg::RID_W-1:0]  rid_shadow = '0;

    t_upsert_result pending_results [$];
    int mismatch_count = 0;
    int routes_in = 0;
    int results_out = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    int cycle_count = 0;
    int rid_settings = 0;

    external_route_table_upsert #(.TABLE_DEPTH(DEPTH)) dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg_we                (i_cfg_we),
        .i_cfg_wdata             (i_cfg_wdata),
        .i_in_valid              (i_in_valid),
        .o_in_ready              (o_in_ready),
        .i_destination           (i_destination),
        .i_prefix_len            (i_prefix_len),
        .i_next_hop              (i_next_hop),
        .i_metric                (i_metric),
        .o_out_valid             (o_out_valid),
        .i_out_ready             (i_out_ready),
        .o_status                (o_status),
        .o_originate             (o_originate),
        .o_entry_index           (o_entry_index),
        .o_lsa_link_state_id     (o_lsa_link_state_id),
        .o_lsa_advertising_router(o_lsa_advertising_router)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", LIMIT,
                     pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic t_upsert_result predict_upsert(
        input logic [ertu_pkg::DEST_W-1:0] d,
        input logic [ertu_pkg::PLEN_W-1:0] p,
        input logic [ertu_pkg::HOP_W-1:0]  h,
        input logic [ertu_pkg::COST_W-1:0] m
    );
        t_upsert_result r;
        int hit;
        int k;
        hit = -1;
        for (k = 0; k < tbl_count; k++)
            if (hit < 0 && tbl_dest[k] == d && tbl_plen[k] == p)
                hit = k;
        if (hit >= 0) begin
            r.idx = hit[ertu_pkg::IDX_OUT_W-1:0];
            if (tbl_cost[hit] != m) begin
                tbl_cost[hit] = m;
                r.status = ertu_pkg::ST_UPDATED;
                r.originate = 1'b1;
            end else begin
                r.status = ertu_pkg::ST_UNCHANGED;
                r.originate = 1'b0;
            end
        end else if (tbl_count < DEPTH) begin
            tbl_dest[tbl_count] = d;
            tbl_plen[tbl_count] = p;
            tbl_hop[tbl_count]  = h;
            tbl_cost[tbl_count] = m;
            r.idx = tbl_count[ertu_pkg::IDX_OUT_W-1:0];
            r.status = ertu_pkg::ST_ADDED;
            r.originate = 1'b1;
            tbl_count++;
        end else begin
            r.idx = '0;
            r.status = ertu_pkg::ST_FULL;
            r.originate = 1'b0;
        end
        r.lsid = r.originate ? d : '0;
        r.adv  = r.originate ? rid_shadow : '0;
        return r;
    endfunction

    task automatic log_mismatch(input string what, input t_upsert_result want,
                                input t_upsert_result got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("result %0d %s: want st=%0d org=%0d idx=%0d lsid=%h adv=%h",
                     results_out, what, want.status, want.originate, want.idx,
                     want.lsid, want.adv);
            $display("    got st=%0d org=%0d idx=%0d lsid=%h adv=%h",
                     got.status, got.originate, got.idx, got.lsid, got.adv);
        end
    endtask

    // scoreboard: check the result beat first, then predict the route beat
    always @(posedge i_clk) begin
        t_upsert_result got;
        t_upsert_result want;
        t_upsert_result guess;
        if (i_rst_n) begin
            if (i_cfg_we)
                rid_shadow = i_cfg_wdata;
            if (o_out_valid && i_out_ready) begin
                got.status    = ertu_pkg::t_status'(o_status);
                got.originate = o_originate;
                got.idx       = o_entry_index;
                got.lsid      = o_lsa_link_state_id;
                got.adv       = o_lsa_advertising_router;
                if (pending_results.size() == 0) begin
                    log_mismatch("with nothing pending", '0, got);
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.originate !== want.originate ||
                        got.idx !== want.idx || got.lsid !== want.lsid ||
                        got.adv !== want.adv)
                        log_mismatch("field mismatch", want, got);
                end
                status_seen[o_status]++;
                results_out++;
            end
            if (i_in_valid && o_in_ready) begin
                guess = predict_upsert(i_destination, i_prefix_len, i_next_hop, i_metric);
                if (row_typed) begin
                    guess.status    = row_status;
                    guess.originate = row_orig;
                    guess.idx       = row_idx;
                    guess.lsid      = row_orig ? i_destination : '0;
                    guess.adv       = row_orig ? rid_shadow : '0;
                end
                pending_results.push_back(guess);
                routes_in++;
            end
        end
    end

    always @(posedge i_clk)
        i_out_ready <= !out_hold && (steady || $urandom_range(99) >= 36);

    // long receiver stall so the block backs up and holds its input
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        out_hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        out_hold <= 1'b0;
    end

    // stimulus-side view of stored routes, used to aim hits and near misses
    logic [ertu_pkg::DEST_W-1:0] known_dest [DEPTH];
    logic [ertu_pkg::PLEN_W-1:0] known_plen [DEPTH];
    logic [ertu_pkg::COST_W-1:0] known_cost [DEPTH];
    int                          known_n = 0;

    task automatic send_route(input t_route_row row);
        int gap;
        int j;
        logic found;
        gap = 0;
        while (!steady && $urandom_range(99) < 36)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_destination <= row.dest;
        i_prefix_len  <= row.plen;
        i_next_hop    <= row.hop;
        i_metric      <= row.metric;
        row_typed     <= row.typed;
        row_status    <= row.status;
        row_orig      <= row.orig;
        row_idx       <= row.idx;
        found = 1'b0;
        for (j = 0; j < known_n; j++)
            if (!found && known_dest[j] == row.dest && known_plen[j] == row.plen) begin
                known_cost[j] = row.metric;
                found = 1'b1;
            end
        if (!found && known_n < DEPTH) begin
            known_dest[known_n] = row.dest;
            known_plen[known_n] = row.plen;
            known_cost[known_n] = row.metric;
            known_n++;
        end
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // idle the route channel, wait out every result, then write the router id
    task automatic set_router_id(input logic [ertu_pkg::RID_W-1:0] rid);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= rid;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        rid_settings++;
    endtask

    function automatic logic [ertu_pkg::COST_W-1:0] pick_metric();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return v[ertu_pkg::COST_W-1:0];
        endcase
    endfunction

    t_route_row dir_rows [N_DIR];

    initial begin
        t_route_row row;
        int n;
        int ph;
        int j;
        int kind;
        int bitpos;
        logic [31:0] pv;
        dir_rows = '{
            '{32'h0000_0000, 6'd0,  32'h0000_0000, 24'h000000,
              1'b1, ertu_pkg::ST_ADDED,     1'b1, 6'd0},
            '{32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF, 24'hFFFFFF,
              1'b1, ertu_pkg::ST_ADDED,     1'b1, 6'd1},
            '{32'h0000_0000, 6'd0,  32'h0A00_0001, 24'h000000,
              1'b1, ertu_pkg::ST_UNCHANGED, 1'b0, 6'd0},
            '{32'h0000_0000, 6'd0,  32'h0000_0000, 24'hFFFFFF,
              1'b1, ertu_pkg::ST_UPDATED,   1'b1, 6'd0},
            '{32'hFFFF_FFFF, 6'd32, 32'h0000_0000, 24'h000000,
              1'b1, ertu_pkg::ST_UPDATED,   1'b1, 6'd1},
            '{32'hFFFF_FFFF, 6'd31, 32'hC0A8_0001, 24'h000010,
              1'b1, ertu_pkg::ST_ADDED,     1'b1, 6'd2},
            '{32'h0000_0000, 6'd63, 32'h0101_0101, 24'h000005,
              1'b1, ertu_pkg::ST_ADDED,     1'b1, 6'd3},
            '{32'h0000_0000, 6'd63, 32'h0202_0202, 24'h000005,
              1'b1, ertu_pkg::ST_UNCHANGED, 1'b0, 6'd3},
            '{32'h0A00_0000, 6'd8,  32'h0A00_00FE, 24'h000014,
              1'b1, ertu_pkg::ST_ADDED,     1'b1, 6'd4},
            '{32'h0A00_0000, 6'd8,  32'h0A00_00FD, 24'h000014,
              1'b1, ertu_pkg::ST_UNCHANGED, 1'b0, 6'd4},
            '{32'h0A00_0000, 6'd24, 32'h0A00_00FE, 24'h000014,
              1'b1, ertu_pkg::ST_ADDED,     1'b1, 6'd5},
            '{32'h0000_0000, 6'd1,  32'h0000_0000, 24'hFFFFFF,
              1'b1, ertu_pkg::ST_ADDED,     1'b1, 6'd6},
            '{32'hAAAA_AAAA, 6'h2A, 32'h5555_5555, 24'hAAAAAA,
              1'b0, ertu_pkg::ST_UNCHANGED, 1'b0, 6'd0},
            '{32'h5555_5555, 6'h15, 32'hAAAA_AAAA, 24'h555555,
              1'b0, ertu_pkg::ST_UNCHANGED, 1'b0, 6'd0},
            '{32'hFFFF_FFFF, 6'd32, 32'h1234_5678, 24'h000000,
              1'b1, ertu_pkg::ST_UNCHANGED, 1'b0, 6'd1},
            '{32'h0000_0000, 6'd63, 32'h0000_0000, 24'h000006,
              1'b0, ertu_pkg::ST_UNCHANGED, 1'b0, 6'd0}
        };
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_router_id(32'hFFFF_FFFF);
        for (n = 0; n < N_DIR; n++)
            send_route(dir_rows[n]);

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_router_id(32'h0000_0000);
                1: set_router_id($urandom);
                2: set_router_id(32'h8000_0001);
                default: set_router_id($urandom);
            endcase
            steady  <= (ph == 1);
            hold_go <= (ph == 2);
            for (n = 0; n < PHASE_LEN; n++) begin
                row = '0;
                row.hop = $urandom;
                row.metric = pick_metric();
                kind = $urandom_range(99);
                j = (known_n > 0) ? $urandom_range(known_n - 1) : 0;
                if (kind < 45 && known_n > 0) begin
                    // hit a stored route, half of them with the cost it already has
                    row.dest = known_dest[j];
                    row.plen = known_plen[j];
                    if ($urandom_range(1))
                        row.metric = known_cost[j];
                end else if (kind < 60 && known_n > 0) begin
                    // near miss: one bit off in the destination or the prefix length
                    row.dest = known_dest[j];
                    row.plen = known_plen[j];
                    if ($urandom_range(1)) begin
                        bitpos = $urandom_range(ertu_pkg::PLEN_W - 1);
                        row.plen[bitpos] = ~row.plen[bitpos];
                    end else begin
                        bitpos = $urandom_range(ertu_pkg::DEST_W - 1);
                        row.dest[bitpos] = ~row.dest[bitpos];
                    end
                end else begin
                    row.dest = $urandom;
                    pv = ($urandom_range(9) == 0) ? $urandom_range(33, 63)
                                                  : $urandom_range(32);
                    row.plen = pv[ertu_pkg::PLEN_W-1:0];
                end
                send_route(row);
            end
        end

        i_in_valid <= 1'b0;
        steady <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("%0d routes in, %0d results out, %0d router id settings, %0d stored",
                 routes_in, results_out, rid_settings, tbl_count);
        $display("unchanged %0d, cost updated %0d, added %0d, table full %0d; %0d mismatches",
                 status_seen[ertu_pkg::ST_UNCHANGED], status_seen[ertu_pkg::ST_UPDATED],
                 status_seen[ertu_pkg::ST_ADDED], status_seen[ertu_pkg::ST_FULL],
                 mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0 && routes_in == results_out)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
